// File: rtl/core/time_of_day_clock_with_set_mode_defines.svh
// Assertion macros for the time-of-day clock RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TIME_OF_DAY_CLOCK_WITH_SET_MODE_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_SET_MODE_DEFINES_SVH

`ifndef SYNTHESIS

// Implication check, clocked, disabled while reset is asserted
`define TOD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication check, clocked, disabled while reset is asserted
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Invariant that holds on every clock edge out of reset
`define TOD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`else

`define TOD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TOD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define TOD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/core/tod_clk_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the time-of-day clock.
// No dependencies; used by time_of_day_clock_with_set_mode.
package tod_clk_pkg;

    // Command carried in the input tuser
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_MODE = 2'd2
    } t_cmd;

    // Field currently being set
    typedef enum logic [1:0] {
        FIELD_NONE = 2'd0,
        FIELD_SEC  = 2'd1,
        FIELD_MIN  = 2'd2,
        FIELD_HOUR = 2'd3
    } t_field;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_TPS      = 1'b1;

    // Configuration reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd150;
    localparam logic [7:0]  TPS_RST      = 8'd125;

    // Blink period in postscaler ticks and the multiples that fit in 8 bits
    localparam int BLINK_TICKS = 62;
    localparam int BLINK_MULTS = 255 / BLINK_TICKS + 1;

    // Time limits
    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    // True when the postscaler value is a multiple of the blink period
    function automatic logic blink_hit(input logic [7:0] value);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < BLINK_MULTS; k++) begin
            if (value == 8'(k * BLINK_TICKS)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// File: rtl/core/time_of_day_clock_with_set_mode.sv
`timescale 1ns / 1ps
// Time-of-day clock (hours, minutes, seconds) with button set mode.
// Depends on tod_clk_pkg and time_of_day_clock_with_set_mode_defines.svh.

// Each input beat (timer tick, set press or mode press) produces exactly one
// output beat with the time, set mode and blink flag after that event. The
// block takes one beat per clock while the result stream is not stalled: an
// input register, then one pass of counter and debounce logic into the result
// register. Backpressure on the master side stalls both stages. Presses are
// debounced per button against the 32-bit millisecond timestamp; the
// configuration port should be written only while no beats are in flight.
`include "time_of_day_clock_with_set_mode_defines.svh"

module time_of_day_clock_with_set_mode (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [4:0] hours, [10:5] minutes, [16:11] secs,
                                        // [18:17] set_field, [19] setting_active,
                                        // [20] blink, [23:21] zero
);

    // Configuration registers
    logic [15:0] r_debounce;
    logic [7:0]  r_tps;

    // Input stage
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [31:0] r_now;

    // Clock state
    logic [5:0]          r_sec,  n_sec;
    logic [5:0]          r_min,  n_min;
    logic [4:0]          r_hour, n_hour;
    tod_clk_pkg::t_field r_field, n_field;
    logic [7:0]          r_pre,  n_pre;
    logic                r_blink, n_blink;
    logic [31:0]         r_last_set, n_last_set;
    logic [31:0]         r_last_mode, n_last_mode;

    // Output stage
    logic        r_out_valid;
    logic [23:0] r_out_data;

    // Handshake
    logic w_out_load;
    logic w_in_load;
    logic w_fire;

    assign w_out_load    = !r_out_valid || m_axis_tready;
    assign w_in_load     = !r_in_valid || w_out_load;
    assign w_fire        = r_in_valid && w_out_load;
    assign s_axis_tready = w_in_load;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= tod_clk_pkg::DEBOUNCE_RST;
            r_tps      <= tod_clk_pkg::TPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tod_clk_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_wdata;
                tod_clk_pkg::CFG_TPS:      r_tps      <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_load) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && s_axis_tvalid) begin
            r_cmd <= s_axis_tuser;
            r_now <= s_axis_tdata;
        end
    end

    // Event processing
    always_comb begin
        logic [7:0]  pre_inc;
        logic        sec_edge;
        logic        set_ok;
        logic        mode_ok;
        logic [31:0] set_gap;
        logic [31:0] mode_gap;

        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_field     = r_field;
        n_pre       = r_pre;
        n_blink     = r_blink;
        n_last_set  = r_last_set;
        n_last_mode = r_last_mode;

        pre_inc  = r_pre + 8'd1;
        sec_edge = (pre_inc >= r_tps);
        set_gap  = r_now - r_last_set;
        mode_gap = r_now - r_last_mode;
        set_ok   = (set_gap > {16'd0, r_debounce});
        mode_ok  = (mode_gap > {16'd0, r_debounce});

        case (tod_clk_pkg::t_cmd'(r_cmd))
            tod_clk_pkg::CMD_TICK: begin
                n_pre = sec_edge ? 8'd0 : pre_inc;
                // second boundary: advance with carries unless being set
                if (sec_edge && (r_field == tod_clk_pkg::FIELD_NONE)) begin
                    if (r_sec == tod_clk_pkg::SEC_MAX) begin
                        n_sec = 6'd0;
                        if (r_min == tod_clk_pkg::MIN_MAX) begin
                            n_min  = 6'd0;
                            n_hour = (r_hour == tod_clk_pkg::HOUR_MAX) ? 5'd0
                                                                       : r_hour + 5'd1;
                        end else begin
                            n_min = r_min + 6'd1;
                        end
                    end else begin
                        n_sec = r_sec + 6'd1;
                    end
                end
                // toggles per blink period hit; at the boundary the two toggles cancel out
                n_blink = r_blink ^ sec_edge ^ tod_clk_pkg::blink_hit(n_pre);
            end
            tod_clk_pkg::CMD_SET: begin
                if (set_ok) begin
                    n_last_set = r_now;
                    // bump the selected field, no carry
                    case (r_field)
                        tod_clk_pkg::FIELD_SEC:
                            n_sec = (r_sec == tod_clk_pkg::SEC_MAX) ? 6'd0 : r_sec + 6'd1;
                        tod_clk_pkg::FIELD_MIN:
                            n_min = (r_min == tod_clk_pkg::MIN_MAX) ? 6'd0 : r_min + 6'd1;
                        tod_clk_pkg::FIELD_HOUR:
                            n_hour = (r_hour == tod_clk_pkg::HOUR_MAX) ? 5'd0
                                                                       : r_hour + 5'd1;
                        default: ;
                    endcase
                end
            end
            tod_clk_pkg::CMD_MODE: begin
                if (mode_ok) begin
                    n_last_mode = r_now;
                    n_field     = tod_clk_pkg::t_field'(r_field + 2'd1);
                end
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= 6'd0;
            r_min       <= 6'd0;
            r_hour      <= 5'd0;
            r_field     <= tod_clk_pkg::FIELD_NONE;
            r_pre       <= 8'd0;
            r_blink     <= 1'b0;
            r_last_set  <= 32'd0;
            r_last_mode <= 32'd0;
        end else if (w_fire) begin
            r_sec       <= n_sec;
            r_min       <= n_min;
            r_hour      <= n_hour;
            r_field     <= n_field;
            r_pre       <= n_pre;
            r_blink     <= n_blink;
            r_last_set  <= n_last_set;
            r_last_mode <= n_last_mode;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {3'd0, n_blink, (n_field != tod_clk_pkg::FIELD_NONE),
                           n_field, n_sec, n_min, n_hour};
        end
    end

    // Checks
    `TOD_ASSERT_ALWAYS(a_time_range, i_clk, i_rst_n,
        (r_sec <= tod_clk_pkg::SEC_MAX) && (r_min <= tod_clk_pkg::MIN_MAX) &&
        (r_hour <= tod_clk_pkg::HOUR_MAX),
        "time counter out of range")
    `TOD_ASSERT_NEXT(a_hold_when_setting, i_clk, i_rst_n,
        w_fire && (r_cmd == tod_clk_pkg::CMD_TICK) && (r_field != tod_clk_pkg::FIELD_NONE),
        $stable(r_sec) && $stable(r_min) && $stable(r_hour),
        "clock advanced while a field is being set")
    `TOD_ASSERT_NEXT(a_in_stage_held, i_clk, i_rst_n,
        r_in_valid && !w_out_load,
        r_in_valid && $stable(r_cmd) && $stable(r_now),
        "pending input beat lost during stall")

endmodule
